// ----- hw/rtl/tfsm_pkg.sv -----
// shared types and constants for the thermal and fan safety monitor
// no dependencies; imported by every module of the block
`default_nettype none

package tfsm_pkg;

    // latched shutdown reason, as it leaves the block
    typedef enum logic [2:0] {
        SD_NONE         = 3'd0,
        SD_TEMP_TIMEOUT = 3'd1,
        SD_TEMP_FATAL   = 3'd2,
        SD_FAN0         = 3'd3,
        SD_FAN1         = 3'd4,
        SD_FAN2         = 3'd5
    } shutdown_code_t;

    // register indexes on the write port
    localparam logic [2:0] REG_WARN_LIMIT    = 3'd0;
    localparam logic [2:0] REG_FATAL_LIMIT   = 3'd1;
    localparam logic [2:0] REG_TIMEOUT_MS    = 3'd2;
    localparam logic [2:0] REG_FAN_WINDOW    = 3'd3;
    localparam logic [2:0] REG_FAN_BAD_LIMIT = 3'd4;

    localparam int NUM_FANS = 3;

    // over-temperature timer width and its saturation value
    localparam int TIMER_BITS = 17;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [11:0] warn_limit;
        logic [11:0] fatal_limit;
        logic [15:0] timeout_ms;
        logic [7:0]  fan_window;
        logic [7:0]  fan_bad_limit;
    } cfg_t;

    // reset values: 50 and 60 degrees, one minute
    localparam cfg_t CFG_RST = '{
        warn_limit:    12'((10 * 50) + 500),
        fatal_limit:   12'((10 * 60) + 500),
        timeout_ms:    16'(60000),
        fan_window:    8'd16,
        fan_bad_limit: 8'd8
    };

    typedef struct packed {
        logic           warning;
        shutdown_code_t code;
    } temp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/thermal_fan_safety_monitor_top.sv -----
// top level of the thermal and fan safety monitor: stream ports, config
// registers, input and result registers, sticky shutdown latch
// depends on tfsm_pkg, tfsm_temp, tfsm_fan
`default_nettype none

// a taken word waits in the input register; its result is registered onto m_tdata
// throughput: one word per cycle unless stalled; the state update is a single compare/add pass
// the input register frees itself whenever the result register can take a word
// reset (rst_n low, async): warning, timer, window and fan counts, latched code
// cleared; config registers return to 1000 / 1100 / 60000 / 16 / 8
module thermal_fan_safety_monitor_top
#(
    parameter int COUNT_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // sample words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // temp_raw[11:0], fan_faults[14:12], elapsed_ms[30:15]

    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // temp_warning[0], fan_status[3:1], shutdown_code[6:4]

    // config write port
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data
);
    import tfsm_pkg::*;

    // config registers
    cfg_t cfg_reg;

    // input register
    logic        in_valid_reg;
    logic [11:0] in_temp_reg;
    logic [2:0]  in_faults_reg;
    logic [15:0] in_elapsed_reg;

    // result register
    logic           out_valid_reg;
    logic           out_warning_reg;
    logic [2:0]     out_status_reg;
    shutdown_code_t out_code_reg;

    // sticky shutdown reason
    shutdown_code_t latched_reg;
    shutdown_code_t latched_next;

    temp_status_t   temp_status;
    shutdown_code_t fan_code;
    logic           advance;

    // the registered sample moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_code_reg, out_status_reg, out_warning_reg};

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WARN_LIMIT:    cfg_reg.warn_limit    <= wr_data[11:0];
                REG_FATAL_LIMIT:   cfg_reg.fatal_limit   <= wr_data[11:0];
                REG_TIMEOUT_MS:    cfg_reg.timeout_ms    <= wr_data;
                REG_FAN_WINDOW:    cfg_reg.fan_window    <= wr_data[7:0];
                REG_FAN_BAD_LIMIT: cfg_reg.fan_bad_limit <= wr_data[7:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_temp_reg    <= s_tdata[11:0];
            in_faults_reg  <= s_tdata[14:12];
            in_elapsed_reg <= s_tdata[30:15];
        end
    end

    // temperature path: warning, timer, timeout and fatal checks
    tfsm_temp u_temp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .cfg        (cfg_reg),
        .temp_raw   (in_temp_reg),
        .elapsed_ms (in_elapsed_reg),
        .status     (temp_status)
    );

    // fan path: window and per-fan counts
    tfsm_fan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .cfg        (cfg_reg),
        .fan_faults (in_faults_reg),
        .code       (fan_code)
    );

    // first reason sticks; temperature beats fan on the same sample
    always_comb
    begin
        if (latched_reg != SD_NONE)
        begin
            latched_next = latched_reg;
        end
        else if (temp_status.code != SD_NONE)
        begin
            latched_next = temp_status.code;
        end
        else
        begin
            latched_next = fan_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= SD_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                latched_reg <= latched_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_warning_reg <= temp_status.warning;
            out_status_reg  <= in_faults_reg;
            out_code_reg    <= latched_next;
        end
    end

    // a latched shutdown never changes until reset
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg != SD_NONE |=> latched_reg == $past(latched_reg))
        else $error("latched shutdown code changed");

    // each result carries the latch value after its own sample
    a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_code_reg == latched_reg)
        else $error("result code differs from latch");

    // stall only while a sample is parked in the input register
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

endmodule

`default_nettype wire

// ----- hw/rtl/tfsm_temp.sv -----
// over-temperature warning, timer and timeout/fatal decision
// depends on tfsm_pkg
`default_nettype none

module tfsm_temp
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire tfsm_pkg::cfg_t        cfg,
    input  wire logic [11:0]           temp_raw,
    input  wire logic [15:0]           elapsed_ms,
    output tfsm_pkg::temp_status_t     status
);
    import tfsm_pkg::*;

    logic                  active_reg;
    logic                  active_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic [TIMER_BITS:0]   timer_sum;
    logic                  over_warn;

    always_comb
    begin
        over_warn   = (temp_raw >= cfg.warn_limit);
        timer_sum   = {1'b0, timer_reg} + (TIMER_BITS + 1)'(elapsed_ms);
        active_next = over_warn;
        if (!over_warn)
        begin
            timer_next = '0;
        end
        else if (!active_reg)
        begin
            // onset sample starts the timer at zero
            timer_next = '0;
        end
        else
        begin
            timer_next = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];
        end

        status.warning = active_next;
        status.code    = SD_NONE;
        if (over_warn)
        begin
            if (timer_next >= TIMER_BITS'(cfg.timeout_ms))
            begin
                status.code = SD_TEMP_TIMEOUT;
            end
            else if (temp_raw >= cfg.fatal_limit)
            begin
                status.code = SD_TEMP_FATAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            timer_reg  <= '0;
        end
        else if (en)
        begin
            active_reg <= active_next;
            timer_reg  <= timer_next;
        end
    end

    // timer only runs while the warning holds
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> timer_reg == '0)
        else $error("timer nonzero without warning");

endmodule

`default_nettype wire

// ----- hw/rtl/tfsm_fan.sv -----
// per-fan bad-sample counters over a sample window, window-end decision
// depends on tfsm_pkg
`default_nettype none

module tfsm_fan
#(
    parameter int COUNT_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire tfsm_pkg::cfg_t          cfg,
    input  wire logic [2:0]              fan_faults,
    output tfsm_pkg::shutdown_code_t     code
);
    import tfsm_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] win_reg;
    logic [COUNT_BITS-1:0] win_inc;
    logic [COUNT_BITS-1:0] win_next;
    logic [COUNT_BITS-1:0] cnt_reg  [NUM_FANS];
    logic [COUNT_BITS-1:0] cnt_inc  [NUM_FANS];
    logic [COUNT_BITS-1:0] cnt_next [NUM_FANS];
    logic [NUM_FANS-1:0]   over_limit;
    logic                  win_end;

    always_comb
    begin
        win_inc = (win_reg == CNT_MAX) ? win_reg : win_reg + 1'b1;
        win_end = (CMP_W'(win_inc) >= CMP_W'(cfg.fan_window)) || (win_inc == CNT_MAX);
        for (int i = 0; i < NUM_FANS; i++)
        begin
            cnt_inc[i] = (fan_faults[i] && cnt_reg[i] != CNT_MAX) ? cnt_reg[i] + 1'b1
                                                                   : cnt_reg[i];
            over_limit[i] = (CMP_W'(cnt_inc[i]) >= CMP_W'(cfg.fan_bad_limit));
            cnt_next[i]   = win_end ? '0 : cnt_inc[i];
        end
        win_next = win_end ? '0 : win_inc;

        // lowest-numbered fan wins
        code = SD_NONE;
        if (win_end)
        begin
            if (over_limit[0])
            begin
                code = SD_FAN0;
            end
            else if (over_limit[1])
            begin
                code = SD_FAN1;
            end
            else if (over_limit[2])
            begin
                code = SD_FAN2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            for (int i = 0; i < NUM_FANS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            win_reg <= win_next;
            for (int i = 0; i < NUM_FANS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_thermal_fan_safety_monitor_top.sv -----
// self-checking testbench for thermal_fan_safety_monitor_top: directed and random samples,
// a shadow model of warning, timer, fan windows and the sticky shutdown latch
// depends on tfsm_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_thermal_fan_safety_monitor_top;

    import tfsm_pkg::*;

    localparam int COUNT_BITS  = 8;
    localparam int CYCLE_LIMIT = 500000;

    // one sample word as packed into s_tdata (temp_raw in the lowest bits)
    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic [2:0]  fan_faults;
        logic [11:0] temp_raw;
    } sample_t;

    // one status word as packed into m_tdata (temp_warning in bit 0)
    typedef struct packed {
        logic           pad;
        shutdown_code_t code;
        logic [2:0]     fan_status;
        logic           warning;
    } status_t;

    typedef struct packed {
        logic                                   active;
        logic [TIMER_BITS-1:0]                  timer;
        logic [COUNT_BITS-1:0]                  win_count;
        logic [NUM_FANS-1:0][COUNT_BITS-1:0]    bad_count;
        shutdown_code_t                         code;
    } thermal_state_t;

    // receiver stall patterns
    typedef enum int {RX_READY, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_pattern_t;

    // ways to reach the one shutdown that a run can show
    typedef enum int {
        TRIP_TIMEOUT,
        TRIP_FATAL,
        TRIP_ZERO_TIMEOUT,
        TRIP_FAN_ORDER,
        TRIP_ZERO_FAN_LIMIT,
        TRIP_TEMP_OVER_FAN
    } trip_case_t;

    localparam shutdown_code_t FAN_CODE [NUM_FANS] = '{SD_FAN0, SD_FAN1, SD_FAN2};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;

    // shadow copy of the block's registers and state
    cfg_t           cfg_now;
    thermal_state_t thermal_state;
    status_t        expected_status [$];

    int  burst_left;
    bit  back_to_back;
    bit  avoid_trip;
    int  hold_request;
    int  mismatch_count;
    int  cycle_count;
    logic [11:0] last_temp;

    thermal_fan_safety_monitor_top #(
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // temp_raw[11:0], fan_faults[14:12], elapsed_ms[30:15]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // temp_warning[0], fan_status[3:1], shutdown_code[6:4]
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one sample through the safety logic: temperature first, then the fan window
    function automatic thermal_state_t advance_thermal_state(input thermal_state_t st,
                                                             input cfg_t c,
                                                             input sample_t smp,
                                                             output status_t res);
        thermal_state_t nxt;
        logic [TIMER_BITS:0] sum;
        bit fan_hit;
        nxt = st;
        fan_hit = 1'b0;
        if (smp.temp_raw >= c.warn_limit)
        begin
            if (!nxt.active)
            begin
                // onset restarts the timer at zero
                nxt.active = 1'b1;
                nxt.timer  = '0;
            end
            else
            begin
                sum = {1'b0, nxt.timer} + (TIMER_BITS+1)'(smp.elapsed_ms);
                nxt.timer = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_BITS-1:0];
            end
            // timeout wins over fatal on the same sample
            if (nxt.code == SD_NONE)
            begin
                if (nxt.timer >= c.timeout_ms)
                    nxt.code = SD_TEMP_TIMEOUT;
                else if (smp.temp_raw >= c.fatal_limit)
                    nxt.code = SD_TEMP_FATAL;
            end
        end
        else
        begin
            nxt.active = 1'b0;
            nxt.timer  = '0;
        end

        if (nxt.win_count != '1)
            nxt.win_count = nxt.win_count + 1'b1;
        for (int i = 0; i < NUM_FANS; i++)
            if (smp.fan_faults[i] && nxt.bad_count[i] != '1)
                nxt.bad_count[i] = nxt.bad_count[i] + 1'b1;

        // window end, also forced when the sample counter saturates
        if (nxt.win_count >= c.fan_window || nxt.win_count == '1)
        begin
            for (int i = 0; i < NUM_FANS; i++)
                if (!fan_hit && nxt.bad_count[i] >= c.fan_bad_limit)
                begin
                    fan_hit = 1'b1;
                    if (nxt.code == SD_NONE)
                        nxt.code = FAN_CODE[i];
                end
            nxt.win_count = '0;
            nxt.bad_count = '0;
        end

        res.pad        = 1'b0;
        res.code       = nxt.code;
        res.fan_status = smp.fan_faults;
        res.warning    = nxt.active;
        return nxt;
    endfunction

    // bend a sample so that it cannot latch a shutdown, keeping the run observable
    function automatic sample_t keep_running(input sample_t smp);
        thermal_state_t trial;
        status_t        res;
        if (thermal_state.code != SD_NONE)
            return smp;
        for (int i = 0; i < NUM_FANS; i++)
            if (int'(thermal_state.bad_count[i]) + 1 >= int'(cfg_now.fan_bad_limit))
                smp.fan_faults[i] = 1'b0;
        trial = advance_thermal_state(thermal_state, cfg_now, smp, res);
        if (trial.code != SD_NONE)
        begin
            smp.temp_raw   = '0;
            smp.elapsed_ms = '0;
        end
        return smp;
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        int t;
        case ($urandom_range(0, 9))
            0, 1:    t = $urandom_range(0, 4095);
            2, 3, 4: t = int'(cfg_now.warn_limit) + int'($urandom_range(0, 40)) - 20;
            5:       t = int'(cfg_now.fatal_limit) + int'($urandom_range(0, 40)) - 20;
            6, 7, 8: t = int'(last_temp);   // runs of the same temperature, such as warning runs
            default: t = $urandom_range(0, 1) ? 4095 : 0;
        endcase
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        smp.temp_raw = 12'(t);
        last_temp = smp.temp_raw;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: smp.elapsed_ms = 16'($urandom_range(0, 255));
            4, 5:       smp.elapsed_ms = 16'($urandom_range(0, 65535));
            6:          smp.elapsed_ms = '0;
            default:    smp.elapsed_ms = 16'($urandom_range(0, int'(cfg_now.timeout_ms)));
        endcase
        smp.fan_faults = 3'($urandom_range(0, 7));
        return smp;
    endfunction

    function automatic cfg_t settings(int warn, int fatal, int timeout, int window, int limit);
        cfg_t c;
        c.warn_limit    = 12'(warn);
        c.fatal_limit   = 12'(fatal);
        c.timeout_ms    = 16'(timeout);
        c.fan_window    = 8'(window);
        c.fan_bad_limit = 8'(limit);
        return c;
    endfunction

    // allow_trip also brings zero warn, timeout and bad limit
    function automatic cfg_t random_settings(bit allow_trip);
        int lo;
        lo = allow_trip ? 0 : 1;
        return settings($urandom_range(lo, 4095),
                        $urandom_range(0, 4095),
                        $urandom_range(0, 1) ? $urandom_range(lo, 2000)
                                             : $urandom_range(lo, 65535),
                        $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255),
                        $urandom_range(0, 1) ? $urandom_range(lo, 10)
                                             : $urandom_range(lo, 255));
    endfunction

    // one word into the block, with bursts and gaps on the sender side
    task automatic send_sample(input sample_t smp);
        status_t res;
        int gap;
        if (avoid_trip)
            smp = keep_running(smp);
        if (burst_left == 0)
        begin
            gap = (!back_to_back && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, smp};
        do
            @(posedge clk);
        while (!s_tready);
        thermal_state = advance_thermal_state(thermal_state, cfg_now, smp, res);
        expected_status.push_back(res);
    endtask

    task automatic send_fields(input int temp, input int faults, input int elapsed);
        sample_t smp;
        smp.temp_raw   = 12'(temp);
        smp.fan_faults = 3'(faults);
        smp.elapsed_ms = 16'(elapsed);
        send_sample(smp);
    endtask

    task automatic send_random_samples(input int count);
        repeat (count)
            send_sample(random_sample());
    endtask

    // sender pauses until every status word is back, then the pipeline latency
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
    endtask

    // all five registers, only while the block is idle
    task automatic apply_config(input cfg_t c);
        wait_drained();
        write_reg(REG_WARN_LIMIT,    16'(c.warn_limit));
        write_reg(REG_FATAL_LIMIT,   16'(c.fatal_limit));
        write_reg(REG_TIMEOUT_MS,    c.timeout_ms);
        write_reg(REG_FAN_WINDOW,    16'(c.fan_window));
        write_reg(REG_FAN_BAD_LIMIT, 16'(c.fan_bad_limit));
        @(negedge clk);
        wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // reset thresholds: onset, timer growth short of the timeout, clearing, fan bits
    task automatic test_reset_defaults();
        send_fields(0, 0, 0);
        send_fields(999, 7, 65535);
        send_fields(1000, 0, 0);
        send_fields(1000, 1, 100);
        send_fields(1099, 2, 59000);
        send_fields(1099, 4, 899);
        send_fields(999, 0, 65535);
        send_fields(1000, 7, 65535);
        send_fields(1050, 7, 0);
        send_fields(1099, 3, 1234);
        send_fields(0, 5, 0);
        send_fields(500, 7, 0);
        repeat (6)
            send_fields(1001, 7, 7);
        send_fields(0, 0, 65535);
    endtask

    // register extremes, including an empty window and a saturating sample counter
    task automatic test_config_extremes();
        apply_config(settings(1, 4095, 65535, 255, 255));
        send_random_samples(300);
        apply_config(settings(0, 4095, 65535, 1, 2));
        send_random_samples(150);
        apply_config(settings(4095, 0, 1, 0, 2));
        send_random_samples(150);
        apply_config(settings(2048, 2500, 5000, 8, 1));
        send_random_samples(100);
    endtask

    task automatic test_random_settings();
        repeat (5)
        begin
            apply_config(random_settings(1'b0));
            send_random_samples(200);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_stall();
        hold_request = 300;
        back_to_back = 1'b1;
        burst_left   = 0;
        send_random_samples(60);
        back_to_back = 1'b0;
        wait_drained();
        send_random_samples(40);
    endtask

    // one shutdown per run; which one is up to the seed
    task automatic test_shutdown();
        trip_case_t pick;
        pick = trip_case_t'($urandom_range(0, 5));

        // flush warning and fan window before the chosen case
        apply_config(settings(int'(cfg_now.warn_limit) == 0 ? 1 : int'(cfg_now.warn_limit),
                              4095, 65535, 0, 255));
        send_fields(0, 0, 0);
        avoid_trip = 1'b0;

        case (pick)
            TRIP_TIMEOUT:
            begin
                apply_config(settings(1000, 4095, 500, 16, 8));
                send_fields(1000, 0, 0);
                send_fields(2000, 1, 499);
                send_fields(2000, 2, 1);
            end
            TRIP_FATAL:
            begin
                apply_config(settings(1000, 3000, 65535, 16, 8));
                send_fields(1000, 0, 0);
                send_fields(2999, 0, 100);
                send_fields(4095, 7, 0);
            end
            TRIP_ZERO_TIMEOUT:
            begin
                // timeout fires on the onset sample, ahead of fatal
                apply_config(settings(1000, 1100, 0, 16, 8));
                send_fields(999, 0, 0);
                send_fields(4095, 0, 0);
            end
            TRIP_FAN_ORDER:
            begin
                // fans 1 and 2 both over the limit, fan 1 reported
                apply_config(settings(4095, 4095, 65535, 4, 2));
                repeat (4)
                    send_fields(0, 6, $urandom_range(0, 65535));
            end
            TRIP_ZERO_FAN_LIMIT:
            begin
                apply_config(settings(4095, 4095, 65535, 3, 0));
                repeat (3)
                    send_fields(0, 0, 0);
            end
            default:
            begin
                // fatal and a fan window end on one sample, temperature wins
                apply_config(settings(100, 200, 65535, 2, 1));
                send_fields(150, 7, 0);
                send_fields(250, 7, 0);
            end
        endcase

        // latched code stays through later faults
        send_fields(4095, 7, 65535);
        send_fields(0, 0, 0);
        send_fields(4095, 1, 65535);

        apply_config(settings(0, 0, 0, 0, 0));
        send_random_samples(30);
        apply_config(settings(4095, 4095, 65535, 255, 255));
        send_random_samples(100);
        repeat (3)
        begin
            apply_config(random_settings(1'b1));
            send_random_samples(100);
        end
    endtask

    task automatic note_failure(input string what, input status_t want, input status_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected warning %0b fans %03b code %0d pad %0b, got warning %0b fans %03b code %0d pad %0b",
                     what, want.warning, want.fan_status, want.code, want.pad,
                     got.warning, got.fan_status, got.code, got.pad);
    endtask

    // status word checker, in order against the shadow model
    always @(posedge clk)
    begin : check_status
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = status_t'(m_tdata);
            if (expected_status.size() == 0)
            begin
                want = '0;
                note_failure("unexpected status word", want, got);
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.warning !== want.warning || got.fan_status !== want.fan_status ||
                    got.code !== want.code || got.pad !== want.pad)
                    note_failure("status mismatch", want, got);
            end
        end
    end

    // receiver: stall pattern changes now and then, plus long hold-offs on request
    initial
    begin : receiver
        rx_pattern_t pattern;
        int pattern_left;
        int hold_left;
        int beat;
        m_tready     = 1'b0;
        pattern      = RX_READY;
        pattern_left = 0;
        hold_left    = 0;
        beat         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (pattern_left == 0)
            begin
                pattern      = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            beat++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (pattern)
                    RX_READY:  m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: m_tready <= (beat % 4 != 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        cfg_now        = CFG_RST;
        thermal_state  = '0;
        burst_left     = 0;
        back_to_back   = 1'b0;
        avoid_trip     = 1'b1;
        hold_request   = 0;
        mismatch_count = 0;
        last_temp      = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_random_settings();
        test_output_stall();
        test_shutdown();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
